// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the timer heap RTL.
// Depends on nothing; the bodies are empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ITH_ASSERT_IMP(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("timer heap check failed");
`define ITH_ASSERT_NXT(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("timer heap check failed");
`else
`define ITH_ASSERT_IMP(lbl, clk, rst_n, a, b)
`define ITH_ASSERT_NXT(lbl, clk, rst_n, a, b)
`endif
`endif

// ===== hdl/ith_pkg.sv =====
// Types, codes and the key compare of the indexed timer heap.
// Used by ith_cell and indexed_timer_heap_top; depends on nothing.
`timescale 1ns / 1ps
package ith_pkg;
    localparam int SLOTS_DEF = 32;
    localparam int SLOT_W = 8;
    localparam int TIME_W = 64;
    localparam int CNT_OUT_W = 6;
    localparam logic [CNT_OUT_W-1:0] POP_LIMIT = 6'd32;

    localparam logic [1:0] OP_ARM = 2'd0;
    localparam logic [1:0] OP_CANCEL = 2'd1;
    localparam logic [1:0] OP_EXPIRE = 2'd2;
    localparam logic [1:0] OP_PEEK = 2'd3;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic              valid;
        logic [TIME_W-1:0] deadline;
        logic [SLOT_W-1:0] slot;
    } t_entry;

    typedef enum logic [1:0] {
        C_HOLD,
        C_REMOVE,
        C_INSERT,
        C_POP
    } t_cell_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FIND,
        S_REMOVE,
        S_INSERT,
        S_EXPIRE
    } t_state;

    function automatic logic earlier(input t_entry a, input t_entry b);
        return {a.deadline, a.slot} < {b.deadline, b.slot};
    endfunction
endpackage

// ===== hdl/ith_cell.sv =====
// One cell of the sorted timer chain: holds one entry, compares and shifts.
// Depends on ith_pkg.
`timescale 1ns / 1ps
module ith_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ith_pkg::t_cell_op i_op,
    input  ith_pkg::t_entry   i_new,
    input  ith_pkg::t_entry   i_rkey,
    input  logic [ith_pkg::SLOT_W-1:0] i_slot,
    input  ith_pkg::t_entry   i_left,
    input  logic              i_left_lt,
    input  ith_pkg::t_entry   i_right,
    output ith_pkg::t_entry   o_ent,
    output logic              o_lt,
    output logic              o_hit
);
    ith_pkg::t_entry r_ent;
    ith_pkg::t_entry n_ent;

    assign o_lt = !r_ent.valid || ith_pkg::earlier(i_new, r_ent);
    assign o_hit = r_ent.valid && (r_ent.slot == i_slot);
    assign o_ent = r_ent;

    always_comb begin
        n_ent = r_ent;
        case (i_op)
            ith_pkg::C_REMOVE: begin
                if (r_ent.valid && !ith_pkg::earlier(r_ent, i_rkey)) begin
                    n_ent = i_right;
                end
            end
            ith_pkg::C_INSERT: begin
                if (i_left_lt) begin
                    n_ent = i_left;
                end else if (o_lt) begin
                    n_ent = i_new;
                end
            end
            ith_pkg::C_POP: begin
                n_ent = i_right;
            end
            default: begin
                n_ent = r_ent;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ent.valid <= 1'b0;
        end else begin
            r_ent <= n_ent;
        end
    end
endmodule

// ===== hdl/indexed_timer_heap_top.sv =====
// Indexed timer queue kept as a sorted chain of SLOTS cells, earliest first.
// Invalid slot and peek answer from idle; cancel runs find, remove; arm adds insert
// unless due; expire gives a result per popped timer plus a final one, each once the last is taken.
// One item at a time: the next is taken once the last result has left.
// Synchronous active-low reset empties the chain and clears the count.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module indexed_timer_heap_top #(
    parameter int SLOTS = ith_pkg::SLOTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_opcode,
    input  logic [7:0]  i_slot,
    input  logic [63:0] i_deadline,
    input  logic [63:0] i_now,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_status,
    output logic        o_fired,
    output logic [4:0]  o_fired_slot,
    output logic [63:0] o_next_deadline,
    output logic [5:0]  o_armed_count,
    output logic [5:0]  o_expired_count,
    output logic        o_last
);
    localparam int CW = $clog2(SLOTS + 1);

    ith_pkg::t_state   r_state, n_state;
    ith_pkg::t_cell_op c_op;
    ith_pkg::t_entry   w_ent [SLOTS];
    ith_pkg::t_entry   w_new, w_rkey, w_hit_key;
    logic [SLOTS-1:0]  w_lt, w_hit;
    logic [CW-1:0]     r_count, n_count;
    logic [5:0]        r_expn, n_expn;
    logic [1:0]        r_op;
    logic [7:0]        r_slot;
    logic [63:0]       r_deadline, r_now;
    ith_pkg::t_entry   r_rkey;
    logic              r_found;
    logic              in_acc, slot_bad, due, load;
    logic              r_out_valid;
    logic [1:0]        r_status, n_status;
    logic              r_fired, n_fired;
    logic [4:0]        r_fslot, n_fslot;
    logic [63:0]       r_nd, n_nd;
    logic [5:0]        r_armed, n_armed, r_expc, n_expc;
    logic              r_last, n_last;

    assign o_ready = (r_state == ith_pkg::S_IDLE) && !r_out_valid;
    assign in_acc = i_valid && o_ready;
    assign slot_bad = {1'b0, i_slot} >= 9'(SLOTS);
    assign due = w_ent[0].valid && (w_ent[0].deadline <= r_now);
    assign w_new = '{valid: 1'b1, deadline: r_deadline, slot: r_slot};
    assign w_rkey = r_rkey;

    for (genvar g = 0; g < SLOTS; g++) begin : g_cell
        ith_pkg::t_entry w_left, w_right;
        logic            w_left_lt;
        if (g == 0) begin : g_first
            assign w_left = '0;
            assign w_left_lt = 1'b0;
        end else begin : g_mid
            assign w_left = w_ent[g-1];
            assign w_left_lt = w_lt[g-1];
        end
        if (g == SLOTS - 1) begin : g_end
            assign w_right = '0;
        end else begin : g_inner
            assign w_right = w_ent[g+1];
        end
        ith_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_op      (c_op),
            .i_new     (w_new),
            .i_rkey    (w_rkey),
            .i_slot    (r_slot),
            .i_left    (w_left),
            .i_left_lt (w_left_lt),
            .i_right   (w_right),
            .o_ent     (w_ent[g]),
            .o_lt      (w_lt[g]),
            .o_hit     (w_hit[g])
        );
    end

    always_comb begin
        w_hit_key = '0;
        for (int k = 0; k < SLOTS; k++) begin
            if (w_hit[k]) begin
                w_hit_key = w_hit_key | w_ent[k];
            end
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ith_pkg::S_IDLE: begin
                if (in_acc) begin
                    if ((i_opcode == ith_pkg::OP_ARM || i_opcode == ith_pkg::OP_CANCEL)
                        && !slot_bad) begin
                        n_state = ith_pkg::S_FIND;
                    end else if (i_opcode == ith_pkg::OP_EXPIRE) begin
                        n_state = ith_pkg::S_EXPIRE;
                    end
                end
            end
            ith_pkg::S_FIND: begin
                n_state = ith_pkg::S_REMOVE;
            end
            ith_pkg::S_REMOVE: begin
                if (r_op == ith_pkg::OP_ARM && !(r_deadline <= r_now)) begin
                    n_state = ith_pkg::S_INSERT;
                end else begin
                    n_state = ith_pkg::S_IDLE;
                end
            end
            ith_pkg::S_INSERT: begin
                n_state = ith_pkg::S_IDLE;
            end
            ith_pkg::S_EXPIRE: begin
                if (!r_out_valid && !(due && r_expn < ith_pkg::POP_LIMIT)) begin
                    n_state = ith_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = ith_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        c_op = ith_pkg::C_HOLD;
        load = 1'b0;
        n_count = r_count;
        n_expn = r_expn;
        n_status = ith_pkg::ST_OK;
        n_fired = 1'b0;
        n_fslot = '0;
        n_nd = '0;
        n_expc = '0;
        n_last = 1'b1;
        n_armed = 6'(r_count);
        case (r_state)
            ith_pkg::S_IDLE: begin
                if (in_acc) begin
                    n_expn = '0;
                    if (i_opcode == ith_pkg::OP_PEEK) begin
                        load = 1'b1;
                        if (r_count == '0) begin
                            n_status = ith_pkg::ST_EMPTY;
                        end else begin
                            n_nd = w_ent[0].deadline;
                        end
                    end else if (i_opcode != ith_pkg::OP_EXPIRE && slot_bad) begin
                        load = 1'b1;
                        n_status = ith_pkg::ST_INVALID;
                    end
                end
            end
            ith_pkg::S_REMOVE: begin
                if (r_found) begin
                    c_op = ith_pkg::C_REMOVE;
                    n_count = r_count - 1'b1;
                end
                n_armed = 6'(n_count);
                if (r_op == ith_pkg::OP_CANCEL) begin
                    load = 1'b1;
                end else if (r_deadline <= r_now) begin
                    load = 1'b1;
                    n_fired = 1'b1;
                    n_fslot = r_slot[4:0];
                    n_nd = r_deadline;
                end
            end
            ith_pkg::S_INSERT: begin
                if (r_count < CW'(SLOTS)) begin
                    c_op = ith_pkg::C_INSERT;
                    n_count = r_count + 1'b1;
                end
                n_armed = 6'(n_count);
                load = 1'b1;
            end
            ith_pkg::S_EXPIRE: begin
                if (!r_out_valid) begin
                    load = 1'b1;
                    if (due && r_expn < ith_pkg::POP_LIMIT) begin
                        c_op = ith_pkg::C_POP;
                        n_count = r_count - 1'b1;
                        n_armed = 6'(n_count);
                        n_expn = r_expn + 1'b1;
                        n_fired = 1'b1;
                        n_fslot = w_ent[0].slot[4:0];
                        n_nd = w_ent[0].deadline;
                        n_last = 1'b0;
                    end else begin
                        n_expc = r_expn;
                    end
                end
            end
            default: begin
                c_op = ith_pkg::C_HOLD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ith_pkg::S_IDLE;
            r_count <= '0;
            r_expn <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_expn <= n_expn;
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_op <= i_opcode;
            r_slot <= i_slot;
            r_deadline <= i_deadline;
            r_now <= i_now;
        end
        if (r_state == ith_pkg::S_FIND) begin
            r_rkey <= w_hit_key;
            r_found <= |w_hit;
        end
        if (load) begin
            r_status <= n_status;
            r_fired <= n_fired;
            r_fslot <= n_fslot;
            r_nd <= n_nd;
            r_armed <= n_armed;
            r_expc <= n_expc;
            r_last <= n_last;
        end
    end

    assign o_valid = r_out_valid;
    assign o_status = r_status;
    assign o_fired = r_fired;
    assign o_fired_slot = r_fslot;
    assign o_next_deadline = r_nd;
    assign o_armed_count = r_armed;
    assign o_expired_count = r_expc;
    assign o_last = r_last;

    `ITH_ASSERT_IMP(a_count_max, i_clk, i_rst_n, 1'b1, r_count <= CW'(SLOTS))
    `ITH_ASSERT_IMP(a_head_tracks_count, i_clk, i_rst_n, 1'b1, (r_count != '0) == w_ent[0].valid)
    `ITH_ASSERT_NXT(a_pop_shrinks, i_clk, i_rst_n, c_op == ith_pkg::C_POP, r_count == CW'($past(r_count) - 1'b1))
endmodule
